FILE: design/rvid_pkg.sv
// Shared types, codes and immediate helpers for the RISC-V instruction decoder.
package rvid_pkg;

  // Major opcodes
  localparam logic [6:0] OPC_LUI     = 7'h37;
  localparam logic [6:0] OPC_AUIPC   = 7'h17;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_BRANCH  = 7'h63;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_OPIMM   = 7'h13;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_OP32    = 7'h3B;
  localparam logic [6:0] OPC_FENCE   = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // Micro-op numbers
  localparam logic [7:0] UOP_ADD     = 8'd1;
  localparam logic [7:0] UOP_SUB     = 8'd2;
  localparam logic [7:0] UOP_SLL     = 8'd3;
  localparam logic [7:0] UOP_SLT     = 8'd4;
  localparam logic [7:0] UOP_SLTU    = 8'd5;
  localparam logic [7:0] UOP_XOR     = 8'd6;
  localparam logic [7:0] UOP_SRL     = 8'd7;
  localparam logic [7:0] UOP_SRA     = 8'd8;
  localparam logic [7:0] UOP_OR      = 8'd9;
  localparam logic [7:0] UOP_AND     = 8'd10;
  localparam logic [7:0] UOP_ADDW    = 8'd11;
  localparam logic [7:0] UOP_SUBW    = 8'd12;
  localparam logic [7:0] UOP_SLLW    = 8'd13;
  localparam logic [7:0] UOP_SRLW    = 8'd14;
  localparam logic [7:0] UOP_SRAW    = 8'd15;
  localparam logic [7:0] UOP_MUL     = 8'd16;
  localparam logic [7:0] UOP_JAL     = 8'd29;
  localparam logic [7:0] UOP_JALR    = 8'd30;
  localparam logic [7:0] UOP_BEQ     = 8'd31;
  localparam logic [7:0] UOP_BNE     = 8'd32;
  localparam logic [7:0] UOP_BLT     = 8'd33;
  localparam logic [7:0] UOP_BGE     = 8'd34;
  localparam logic [7:0] UOP_BLTU    = 8'd35;
  localparam logic [7:0] UOP_BGEU    = 8'd36;
  localparam logic [7:0] UOP_LUI     = 8'd37;
  localparam logic [7:0] UOP_AUIPC   = 8'd38;
  localparam logic [7:0] UOP_LD_BASE = 8'd39;
  localparam logic [7:0] UOP_ST_BASE = 8'd46;
  localparam logic [7:0] UOP_ADDI    = 8'd50;
  localparam logic [7:0] UOP_SLLI    = 8'd51;
  localparam logic [7:0] UOP_SLTI    = 8'd52;
  localparam logic [7:0] UOP_SLTIU   = 8'd53;
  localparam logic [7:0] UOP_XORI    = 8'd54;
  localparam logic [7:0] UOP_SRLI    = 8'd55;
  localparam logic [7:0] UOP_SRAI    = 8'd56;
  localparam logic [7:0] UOP_ORI     = 8'd57;
  localparam logic [7:0] UOP_ANDI    = 8'd58;
  localparam logic [7:0] UOP_ADDIW   = 8'd59;
  localparam logic [7:0] UOP_SLLIW   = 8'd60;
  localparam logic [7:0] UOP_SRLIW   = 8'd61;
  localparam logic [7:0] UOP_SRAIW   = 8'd62;
  localparam logic [7:0] UOP_FENCE   = 8'd63;
  localparam logic [7:0] UOP_ECALL   = 8'd65;
  localparam logic [7:0] UOP_CSR_LO  = 8'd66;  // csrrw/s/c sit at base + funct3
  localparam logic [7:0] UOP_CSR_HI  = 8'd65;  // immediate forms sit at base + funct3
  localparam logic [7:0] UOP_MRET    = 8'd118;
  localparam logic [7:0] UOP_ILLEGAL = 8'd255;

  typedef enum logic [1:0] {
    UNIT_ALU = 2'd0,
    UNIT_MEM = 2'd1,
    UNIT_MUL = 2'd2,
    UNIT_CSR = 2'd3
  } unit_e;

  typedef enum logic [1:0] {
    OP1_NONE = 2'd0,
    OP1_RS1  = 2'd1,
    OP1_PC   = 2'd2,
    OP1_ZERO = 2'd3
  } op1_e;

  typedef enum logic [2:0] {
    OP2_NONE = 3'd0,
    OP2_RS2  = 3'd1,
    OP2_IMM  = 3'd2,
    OP2_IMMU = 3'd3,
    OP2_IMMZ = 3'd4
  } op2_e;

  typedef enum logic [3:0] {
    BR_NONE = 4'd0,
    BR_EQ   = 4'd1,
    BR_NE   = 4'd2,
    BR_LT   = 4'd3,
    BR_GE   = 4'd4,
    BR_LTU  = 4'd5,
    BR_GEU  = 4'd6,
    BR_JAL  = 4'd7,
    BR_JALR = 4'd8
  } br_e;

  typedef enum logic [1:0] {
    DST_NONE = 2'd0,
    DST_INT  = 2'd1,
    DST_X0   = 2'd2
  } dst_e;

  typedef enum logic [1:0] {
    EXC_NONE    = 2'd0,
    EXC_ILLEGAL = 2'd1,
    EXC_ECALL   = 2'd2
  } exc_e;

  // Flag bit positions
  localparam int FLG_LOAD   = 0;
  localparam int FLG_STA    = 1;
  localparam int FLG_LDQ    = 2;
  localparam int FLG_STQ    = 3;
  localparam int FLG_SIGNED = 4;
  localparam int FLG_BR     = 5;
  localparam int FLG_JAL    = 6;
  localparam int FLG_JALR   = 7;
  localparam int FLG_WORD   = 8;
  localparam int FLG_EPC    = 9;
  localparam int FLG_W      = 10;

  typedef struct packed {
    logic [7:0]        uop;
    logic              iq;
    unit_e             unit;
    op1_e              op1;
    op2_e              op2;
    br_e               br;
    logic [31:0]       imm;
    dst_e              dst;
    logic [1:0]        csr_cmd;
    logic [11:0]       csr_num;
    logic [FLG_W-1:0]  flags;
    logic [1:0]        size;
    exc_e              exc;
  } uop_t;

  function automatic logic [31:0] imm_i(input logic [31:0] w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic logic [31:0] imm_s(input logic [31:0] w);
    return {{20{w[31]}}, w[31:25], w[11:7]};
  endfunction

  function automatic logic [31:0] imm_b(input logic [31:0] w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic logic [31:0] imm_u(input logic [31:0] w);
    return {w[31:12], 12'h000};
  endfunction

  function automatic logic [31:0] imm_j(input logic [31:0] w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

endpackage

FILE: design/riscv_instruction_decoder_unit.sv
// RV64 instruction decoder: input register, single-pass decode, result register.
//
// Usage:
//   Input channel (valid_i / stall_o) carries one request: fetch_valid_i,
//   flush_i, the 32-bit instruction_i and pc_low_i. A request is taken at a
//   rising edge where valid_i is high and stall_o is low. A request with
//   fetch_valid_i low or flush_i high is taken and dropped: it yields no
//   micro-op. Every other request yields exactly one micro-op.
//   Output channel (valid_o / stall_i) presents the micro-op fields; the
//   micro-op is taken at an edge where valid_o is high and stall_i is low.
//   Path: a taken request passes through the input register, then the decode
//   logic into the result register, which drives valid_o and the micro-op
//   fields.
//   Throughput: one request per cycle while stall_i is low; the decode is a
//   single combinational pass between the two registers, so both stages advance every cycle while stall_i is low.
//   When the receiver stalls, the result register holds its micro-op; the
//   input register still takes requests until it holds one that yields a
//   micro-op, then stall_o rises until the result register drains.
//   Reset (rst_ni low, asynchronous) empties both stages; no micro-op is
//   presented until a new request has passed through.
module riscv_instruction_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        fetch_valid_i,
  input  logic        flush_i,
  input  logic [31:0] instruction_i,
  input  logic [5:0]  pc_low_i,
  // output channel
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  micro_opcode_o,
  output logic        issue_queue_o,
  output logic [1:0]  unit_code_o,
  output logic [4:0]  operand_selects_o,
  output logic [3:0]  branch_kind_o,
  output logic [31:0] immediate_o,
  output logic [1:0]  dest_kind_o,
  output logic [14:0] register_specifiers_o,
  output logic [13:0] csr_control_o,
  output logic [11:0] flag_bits_o,
  output logic [1:0]  exception_kind_o,
  output logic [5:0]  pc_low_out_o
);
  import rvid_pkg::*;

  // Stage 1: captured instruction; marked valid only for requests that produce a micro-op
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] instr_q;
  logic [5:0]  pc_q;

  // Stage 2: result register
  logic        s2_valid_q, s2_valid_d;
  uop_t        uop_q, uop_d;
  logic [14:0] regs_q;
  logic [5:0]  pc_out_q;

  logic s2_load;
  logic s1_free;
  logic in_take;

  // Result register loads whenever it is empty or its content is taken.
  assign s2_load = !s2_valid_q || !stall_i;
  // Input register frees when empty or its content moves to the result.
  assign s1_free = !s1_valid_q || s2_load;
  assign stall_o = !s1_free;
  assign in_take = valid_i && s1_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_free) begin
      // drop requests without a fetched instruction or under flush
      s1_valid_d = in_take && fetch_valid_i && !flush_i;
    end
  end

  assign s2_valid_d = s2_load ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      instr_q <= instruction_i;
      pc_q    <= pc_low_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      uop_q    <= uop_d;
      regs_q   <= {instr_q[19:15], instr_q[24:20], instr_q[11:7]};
      pc_out_q <= pc_q;
    end
  end

  // Decode of the held instruction
  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rd;

  assign opc = instr_q[6:0];
  assign f3  = instr_q[14:12];
  assign f7  = instr_q[31:25];
  assign rd  = instr_q[11:7];

  always_comb begin
    uop_d          = '0;
    uop_d.uop      = UOP_ILLEGAL;
    uop_d.iq       = 1'b0;
    uop_d.unit     = UNIT_ALU;
    uop_d.op1      = OP1_NONE;
    uop_d.op2      = OP2_NONE;
    uop_d.br       = BR_NONE;
    uop_d.dst      = DST_NONE;
    uop_d.exc      = EXC_NONE;

    unique case (opc)
      OPC_LUI: begin
        uop_d.uop = UOP_LUI;
        uop_d.op1 = OP1_ZERO;
        uop_d.op2 = OP2_IMMU;
        uop_d.imm = imm_u(instr_q);
        uop_d.dst = DST_INT;
      end
      OPC_AUIPC: begin
        uop_d.uop = UOP_AUIPC;
        uop_d.op1 = OP1_PC;
        uop_d.op2 = OP2_IMMU;
        uop_d.imm = imm_u(instr_q);
        uop_d.dst = DST_INT;
      end
      OPC_JAL: begin
        uop_d.uop = UOP_JAL;
        uop_d.op1 = OP1_PC;
        uop_d.op2 = OP2_IMM;
        uop_d.br  = BR_JAL;
        uop_d.imm = imm_j(instr_q);
        uop_d.dst = (rd != 5'd0) ? DST_INT : DST_X0;
        uop_d.flags[FLG_JAL] = 1'b1;
      end
      OPC_JALR: begin
        uop_d.uop = UOP_JALR;
        uop_d.op1 = OP1_RS1;
        uop_d.op2 = OP2_IMM;
        uop_d.br  = BR_JALR;
        uop_d.imm = imm_i(instr_q);
        uop_d.dst = (rd != 5'd0) ? DST_INT : DST_X0;
        uop_d.flags[FLG_JALR] = 1'b1;
      end
      OPC_BRANCH: begin
        uop_d.op1 = OP1_RS1;
        uop_d.op2 = OP2_RS2;
        uop_d.imm = imm_b(instr_q);
        uop_d.flags[FLG_BR] = 1'b1;
        case (f3)
          3'd0: begin uop_d.uop = UOP_BEQ;  uop_d.br = BR_EQ;  end
          3'd1: begin uop_d.uop = UOP_BNE;  uop_d.br = BR_NE;  end
          3'd4: begin uop_d.uop = UOP_BLT;  uop_d.br = BR_LT;  end
          3'd5: begin uop_d.uop = UOP_BGE;  uop_d.br = BR_GE;  end
          3'd6: begin uop_d.uop = UOP_BLTU; uop_d.br = BR_LTU; end
          3'd7: begin uop_d.uop = UOP_BGEU; uop_d.br = BR_GEU; end
          default: uop_d.uop = UOP_ILLEGAL;
        endcase
      end
      OPC_LOAD: begin
        uop_d.iq   = 1'b1;
        uop_d.unit = UNIT_MEM;
        uop_d.op1  = OP1_RS1;
        uop_d.op2  = OP2_IMM;
        uop_d.imm  = imm_i(instr_q);
        uop_d.dst  = DST_INT;
        uop_d.flags[FLG_LOAD]   = 1'b1;
        uop_d.flags[FLG_LDQ]    = 1'b1;
        uop_d.flags[FLG_SIGNED] = 1'b1;
        if (f3 != 3'd7) begin
          uop_d.uop  = UOP_LD_BASE + {5'd0, f3};
          uop_d.size = f3[1:0];
          // unsigned loads
          if (f3[2]) begin
            uop_d.flags[FLG_SIGNED] = 1'b0;
          end
        end
      end
      OPC_STORE: begin
        uop_d.iq   = 1'b1;
        uop_d.unit = UNIT_MEM;
        uop_d.op1  = OP1_RS1;
        uop_d.op2  = OP2_RS2;
        uop_d.imm  = imm_s(instr_q);
        uop_d.flags[FLG_STA] = 1'b1;
        uop_d.flags[FLG_STQ] = 1'b1;
        if (!f3[2]) begin
          uop_d.uop  = UOP_ST_BASE + {5'd0, f3};
          uop_d.size = f3[1:0];
        end
      end
      OPC_OPIMM: begin
        uop_d.op1 = OP1_RS1;
        uop_d.op2 = OP2_IMM;
        uop_d.imm = imm_i(instr_q);
        uop_d.dst = DST_INT;
        case (f3)
          3'd0: uop_d.uop = UOP_ADDI;
          3'd1: uop_d.uop = UOP_SLLI;
          3'd2: uop_d.uop = UOP_SLTI;
          3'd3: uop_d.uop = UOP_SLTIU;
          3'd4: uop_d.uop = UOP_XORI;
          3'd5: uop_d.uop = (f7 == F7_ZERO) ? UOP_SRLI : UOP_SRAI;
          3'd6: uop_d.uop = UOP_ORI;
          default: uop_d.uop = UOP_ANDI;
        endcase
      end
      OPC_OPIMM32: begin
        uop_d.op1 = OP1_RS1;
        uop_d.op2 = OP2_IMM;
        uop_d.imm = imm_i(instr_q);
        uop_d.dst = DST_INT;
        uop_d.flags[FLG_WORD] = 1'b1;
        case (f3)
          3'd0: uop_d.uop = UOP_ADDIW;
          3'd1: uop_d.uop = UOP_SLLIW;
          3'd5: uop_d.uop = (f7 == F7_ZERO) ? UOP_SRLIW : UOP_SRAIW;
          default: uop_d.uop = UOP_ILLEGAL;
        endcase
      end
      OPC_OP: begin
        uop_d.op1 = OP1_RS1;
        uop_d.op2 = OP2_RS2;
        uop_d.dst = DST_INT;
        if (f7 == F7_MULDIV) begin
          // only MUL of the M extension is supported
          uop_d.unit = UNIT_MUL;
          if (f3 == 3'd0) begin
            uop_d.uop = UOP_MUL;
          end
        end else begin
          case (f3)
            3'd0: uop_d.uop = (f7 == F7_ALT) ? UOP_SUB : UOP_ADD;
            3'd1: uop_d.uop = UOP_SLL;
            3'd2: uop_d.uop = UOP_SLT;
            3'd3: uop_d.uop = UOP_SLTU;
            3'd4: uop_d.uop = UOP_XOR;
            3'd5: uop_d.uop = (f7 == F7_ALT) ? UOP_SRA : UOP_SRL;
            3'd6: uop_d.uop = UOP_OR;
            default: uop_d.uop = UOP_AND;
          endcase
        end
      end
      OPC_OP32: begin
        uop_d.op1 = OP1_RS1;
        uop_d.op2 = OP2_RS2;
        uop_d.dst = DST_INT;
        uop_d.flags[FLG_WORD] = 1'b1;
        case (f3)
          3'd0: uop_d.uop = (f7 == F7_ALT) ? UOP_SUBW : UOP_ADDW;
          3'd1: uop_d.uop = UOP_SLLW;
          3'd5: uop_d.uop = (f7 == F7_ALT) ? UOP_SRAW : UOP_SRLW;
          default: uop_d.uop = UOP_ILLEGAL;
        endcase
      end
      OPC_FENCE: begin
        uop_d.uop  = UOP_FENCE;
        uop_d.iq   = 1'b1;
        uop_d.unit = UNIT_MEM;
      end
      OPC_SYSTEM: begin
        uop_d.unit = UNIT_CSR;
        if (f3 == 3'd0) begin
          // ecall when rd and bits 31:20 are zero; every other word here is mret
          if (rd == 5'd0 && instr_q[31:20] == 12'h000) begin
            uop_d.uop = UOP_ECALL;
            uop_d.exc = EXC_ECALL;
            uop_d.flags[FLG_EPC] = 1'b1;
          end else begin
            uop_d.uop = UOP_MRET;
          end
        end else begin
          uop_d.op1      = OP1_RS1;
          uop_d.op2      = OP2_IMMZ;
          uop_d.csr_num  = instr_q[31:20];
          uop_d.dst      = DST_INT;
          if (f3 != 3'd4) begin
            uop_d.uop     = f3[2] ? (UOP_CSR_HI + {5'd0, f3}) : (UOP_CSR_LO + {5'd0, f3});
            uop_d.csr_cmd = f3[1:0];
          end
        end
      end
      default: uop_d.uop = UOP_ILLEGAL;
    endcase

    if (uop_d.uop == UOP_ILLEGAL) begin
      uop_d.exc = EXC_ILLEGAL;
    end
  end

  // Output ports
  assign valid_o               = s2_valid_q;
  assign micro_opcode_o        = uop_q.uop;
  assign issue_queue_o         = uop_q.iq;
  assign unit_code_o           = uop_q.unit;
  assign operand_selects_o     = {uop_q.op1, uop_q.op2};
  assign branch_kind_o         = uop_q.br;
  assign immediate_o           = uop_q.imm;
  assign dest_kind_o           = uop_q.dst;
  assign register_specifiers_o = regs_q;
  assign csr_control_o         = {uop_q.csr_cmd, uop_q.csr_num};
  assign flag_bits_o           = {uop_q.size, uop_q.flags};
  assign exception_kind_o      = uop_q.exc;
  assign pc_low_out_o          = pc_out_q;

  // Assertions
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (s1_valid_q && valid_o && stall_i))
    else $error("stall raised while a stage could advance");

  a_s1_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !(valid_o && stall_i)) |=> valid_o)
    else $error("held instruction did not reach the result register");

  a_illegal_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && micro_opcode_o == UOP_ILLEGAL) |-> (exception_kind_o == EXC_ILLEGAL))
    else $error("illegal micro-op without illegal-instruction cause");

  a_ecall_epc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && exception_kind_o == EXC_ECALL)
      |-> (flag_bits_o[FLG_EPC] && unit_code_o == UNIT_CSR))
    else $error("environment call without pc-to-epc on the CSR unit");

  a_memq_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && issue_queue_o) |-> (unit_code_o == UNIT_MEM))
    else $error("memory queue micro-op not routed to the memory unit");

endmodule
